// ----- design/tanh_soft_clip_distortion_macros.svh -----
// ----------------------------------------------------------------------------
// tanh_soft_clip_distortion_macros.svh
// Assertion shorthands used by the soft clipper top level.
// ----------------------------------------------------------------------------
`ifndef TANH_SOFT_CLIP_DISTORTION_MACROS_SVH
`define TANH_SOFT_CLIP_DISTORTION_MACROS_SVH

// same-cycle implication, checked out of reset
`define TSCD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tscd: same-cycle check failed");

// next-cycle implication, checked out of reset
`define TSCD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tscd: next-cycle check failed");

`endif

// ----- design/tscd_pkg.sv -----
// ----------------------------------------------------------------------------
// tscd_pkg
// Shared types, register map and table generator for the soft clipper.
// ----------------------------------------------------------------------------
package tscd_pkg;

    localparam int CFG_W    = 16;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;
    localparam int REG_IW   = 2;

    // register indexes (byte address = 4 * index)
    localparam logic [REG_IW-1:0] REG_DRIVE_GAIN  = 2'd0;
    localparam logic [REG_IW-1:0] REG_WET_MIX     = 2'd1;
    localparam logic [REG_IW-1:0] REG_OUTPUT_GAIN = 2'd2;

    localparam logic [CFG_W-1:0] DRIVE_GAIN_RST  = 16'd8192;
    localparam logic [CFG_W-1:0] WET_MIX_RST     = 16'd16384;
    localparam logic [CFG_W-1:0] OUTPUT_GAIN_RST = 16'd16384;
    localparam logic [CFG_W-1:0] MIX_FULL        = 16'd32768;

    localparam int FRAC_W = 16;

    // stage load enables handed to the submodules
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } tscd_shp_adv_t;

    typedef struct packed {
        logic s5;
        logic s6;
    } tscd_mix_adv_t;

    // restoring division, used only while building the table at elaboration
    function automatic logic [63:0] tscd_udiv(logic [63:0] a, logic [63:0] b);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int j = 63; j >= 0; j--)
        begin
            r = {r[62:0], a[j]};
            if (r >= b)
            begin
                r    = r - b;
                q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh(4*idx/n) in Q0.f, built with exact integer steps:
    // r = exp(-8/n) in Q31 by truncated Taylor series, e = r^idx,
    // entry = round((1 - e) / (1 + e))
    function automatic logic [63:0] tscd_tanh_entry(int unsigned n, int unsigned f,
                                                    int unsigned idx);
        logic [63:0] one;
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] den;
        one  = 64'd1 << 31;
        y    = tscd_udiv(64'd1 << 34, 64'(n));
        term = one;
        r    = one;
        e    = one;
        for (int k = 1; k <= 14; k++)
        begin
            term = tscd_udiv((term * y) >> 31, 64'(k));
            if (k % 2 == 1)
                r = r - term;
            else
                r = r + term;
        end
        for (int unsigned i = 0; i < idx; i++)
        begin
            e = (e * r + (64'd1 << 30)) >> 31;
        end
        num = (one - e) << f;
        den = one + e;
        return tscd_udiv(num + (den >> 1), den);
    endfunction

endpackage

// ----- design/tscd_if.sv -----
// ----------------------------------------------------------------------------
// tscd_if
// Valid/ready stream interfaces for input and output sample words.
// ----------------------------------------------------------------------------
interface tscd_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          frame_end_in;

    modport source (output valid, output sample_in, output frame_end_in, input ready);
    modport sink   (input valid, input sample_in, input frame_end_in, output ready);
endinterface

interface tscd_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          frame_end_out;

    modport source (output valid, output sample_out, output frame_end_out, input ready);
    modport sink   (input valid, input sample_out, input frame_end_out, output ready);
endinterface

// ----- design/tanh_soft_clip_distortion.sv -----
// ----------------------------------------------------------------------------
// tanh_soft_clip_distortion
// Throughput: one word per cycle while the output is not stalled; six register
// stages, each with its own valid. Reset (rst_n low, async): pipeline empties,
// registers return to drive 2.0, mix 0.5, output gain 1.0. The tanh table is
// constant logic.
// ----------------------------------------------------------------------------
`include "tanh_soft_clip_distortion_macros.svh"

module tanh_soft_clip_distortion
    import tscd_pkg::*;
#(
    parameter int SAMPLE_BITS        = 16,
    parameter int TANH_TABLE_ENTRIES = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    tscd_in_if.sink             din,
    tscd_out_if.source          dout,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int SB = SAMPLE_BITS;
    localparam int PW = SB + 17;
    localparam int NSTG = 6;

    // ------------------------------------------------------------------
    // Configuration registers (APB, no wait states)
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]  drive_gain_reg;
    logic [CFG_W-1:0]  wet_mix_reg;
    logic [CFG_W-1:0]  output_gain_reg;
    logic              cfg_wr;
    logic [REG_IW-1:0] cfg_idx;
    logic              drive_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign cfg_idx  = paddr[REG_IW+1:2];
    assign drive_wr = cfg_wr && (cfg_idx == REG_DRIVE_GAIN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_gain_reg  <= DRIVE_GAIN_RST;
            wet_mix_reg     <= WET_MIX_RST;
            output_gain_reg <= OUTPUT_GAIN_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_DRIVE_GAIN:  drive_gain_reg  <= pwdata[CFG_W-1:0];
                REG_WET_MIX:     wet_mix_reg     <= pwdata[CFG_W-1:0];
                REG_OUTPUT_GAIN: output_gain_reg <= pwdata[CFG_W-1:0];
                default:         ;  // unmapped: dropped
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_DRIVE_GAIN:  prdata = APB_DW'(drive_gain_reg);
            REG_WET_MIX:     prdata = APB_DW'(wet_mix_reg);
            REG_OUTPUT_GAIN: prdata = APB_DW'(output_gain_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // A stage loads when it is empty or its successor loads, so a stall
    // at the output backs up one stage at a time and bubbles get squeezed
    // out. Input is taken whenever stage 1 can load.
    // ------------------------------------------------------------------
    logic [NSTG:1] v_reg;
    logic [NSTG:1] v_next;
    logic [NSTG:1] ld;

    always_comb
    begin
        ld[NSTG] = !v_reg[NSTG] || dout.ready;
        for (int k = NSTG - 1; k >= 1; k--)
        begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
    end

    always_comb
    begin
        v_next = v_reg;
        if (ld[1])
            v_next[1] = din.valid;
        for (int k = 2; k <= NSTG; k++)
        begin
            if (ld[k])
                v_next[k] = v_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign din.ready  = ld[1];
    assign dout.valid = v_reg[NSTG];

    // ------------------------------------------------------------------
    // Stage 1: drive gain, exact product with F+12 fraction bits
    // ------------------------------------------------------------------
    logic signed [CFG_W:0]  drive_s;
    logic signed [PW-1:0]   p_mul;

    assign drive_s = $signed({1'b0, drive_gain_reg});
    assign p_mul   = PW'(din.sample_in) * PW'(drive_s);

    logic signed [PW-1:0]   p1_reg;
    logic signed [SB-1:0]   s1_reg;
    logic                   fe1_reg;

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            p1_reg  <= p_mul;
            s1_reg  <= din.sample_in;
            fe1_reg <= din.frame_end_in;
        end
    end

    // ------------------------------------------------------------------
    // Stages 2-4: tanh shaper
    // ------------------------------------------------------------------
    tscd_shp_adv_t        shp_adv;
    logic signed [SB:0]   wet4;
    logic signed [SB-1:0] dry4;
    logic                 fe4;

    assign shp_adv.s2 = ld[2];
    assign shp_adv.s3 = ld[3];
    assign shp_adv.s4 = ld[4];

    tscd_shaper #(
        .SAMPLE_BITS        (SAMPLE_BITS),
        .TANH_TABLE_ENTRIES (TANH_TABLE_ENTRIES)
    ) u_shaper (
        .clk     (clk),
        .adv     (shp_adv),
        .p       (p1_reg),
        .dry_in  (s1_reg),
        .fe_in   (fe1_reg),
        .wet     (wet4),
        .dry_out (dry4),
        .fe_out  (fe4)
    );

    // ------------------------------------------------------------------
    // Stages 5-6: blend and output gain; stage 6 is the output register
    // ------------------------------------------------------------------
    tscd_mix_adv_t mix_adv;

    assign mix_adv.s5 = ld[5];
    assign mix_adv.s6 = ld[6];

    tscd_mixer #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mixer (
        .clk           (clk),
        .adv           (mix_adv),
        .wet           (wet4),
        .dry           (dry4),
        .fe_in         (fe4),
        .wet_mix       (wet_mix_reg),
        .output_gain   (output_gain_reg),
        .sample_out    (dout.sample_out),
        .frame_end_out (dout.frame_end_out)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // input backpressure only when every stage is full and the sink stalls
    `TSCD_ASSERT_NOW(a_ready_full, !din.ready, ($countones(v_reg) == NSTG) && !dout.ready)
    // an accepted word always lands in stage 1
    `TSCD_ASSERT_NEXT(a_accept_lands, din.valid && din.ready, v_reg[1])
    // a stalled result is kept
    `TSCD_ASSERT_NEXT(a_out_kept, dout.valid && !dout.ready, dout.valid)
    // a drive gain write takes effect on the next cycle
    `TSCD_ASSERT_NEXT(a_cfg_drive, drive_wr, drive_gain_reg == $past(pwdata[CFG_W-1:0]))

endmodule

// ----- design/tscd_shaper.sv -----
// ----------------------------------------------------------------------------
// tscd_shaper
// Tanh shaper: magnitude and table index, table read, interpolation.
// Three register stages; the dry sample and flag ride along.
// ----------------------------------------------------------------------------
module tscd_shaper
    import tscd_pkg::*;
#(
    parameter int SAMPLE_BITS        = 16,
    parameter int TANH_TABLE_ENTRIES = 256
)
(
    input  logic                          clk,
    input  tscd_shp_adv_t                 adv,
    input  logic signed [SAMPLE_BITS+16:0] p,
    input  logic signed [SAMPLE_BITS-1:0] dry_in,
    input  logic                          fe_in,
    output logic signed [SAMPLE_BITS:0]   wet,
    output logic signed [SAMPLE_BITS-1:0] dry_out,
    output logic                          fe_out
);

    localparam int SB   = SAMPLE_BITS;
    localparam int N    = TANH_TABLE_ENTRIES;
    localparam int F    = SB - 1;
    localparam int PW   = SB + 17;
    localparam int MW   = SB + 16;
    localparam int TW   = $clog2(N + 1);
    localparam int POSW = MW + TW;
    localparam int IDXW = POSW - (F + 14);
    localparam logic [SB:0] TMAX = {2'b00, {F{1'b1}}};

    // constant tanh table, N+1 points over magnitudes 0..4
    logic [SB-1:0] rom_lut [0:N];

    for (genvar gi = 0; gi <= N; gi++)
    begin : g_rom
        localparam logic [63:0] ENTRY = tscd_tanh_entry(N, F, gi);
        assign rom_lut[gi] = ENTRY[SB-1:0];
    end

    // stage 2: magnitude, scaled position
    logic            neg;
    logic [MW-1:0]   mag;
    logic [POSW-1:0] pos;
    logic [IDXW-1:0] idx_full;
    logic            sat;

    assign neg      = p[PW-1];
    assign mag      = neg ? MW'(-p) : MW'(p);
    assign pos      = POSW'(mag) * POSW'(N);
    assign idx_full = pos[POSW-1:F+14];
    assign sat      = (idx_full >= IDXW'(N));

    logic [TW-1:0]          idx2_reg;
    logic [FRAC_W-1:0]      frac2_reg;
    logic                   sat2_reg;
    logic                   neg2_reg;
    logic signed [SB-1:0]   dry2_reg;
    logic                   fe2_reg;

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            idx2_reg  <= sat ? '0 : idx_full[TW-1:0];
            frac2_reg <= pos[F+13:F-2];
            sat2_reg  <= sat;
            neg2_reg  <= neg;
            dry2_reg  <= dry_in;
            fe2_reg   <= fe_in;
        end
    end

    // stage 3: table read, segment slope
    logic [TW-1:0] idx_hi;
    logic [SB-1:0] lo_val;
    logic [SB-1:0] hi_val;

    assign idx_hi = TW'(idx2_reg + 1'b1);
    assign lo_val = rom_lut[idx2_reg];
    assign hi_val = rom_lut[idx_hi];

    logic [SB-1:0]        lo3_reg;
    logic [SB-1:0]        diff3_reg;
    logic [FRAC_W-1:0]    frac3_reg;
    logic                 sat3_reg;
    logic                 neg3_reg;
    logic signed [SB-1:0] dry3_reg;
    logic                 fe3_reg;

    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            lo3_reg   <= lo_val;
            diff3_reg <= hi_val - lo_val;
            frac3_reg <= frac2_reg;
            sat3_reg  <= sat2_reg;
            neg3_reg  <= neg2_reg;
            dry3_reg  <= dry2_reg;
            fe3_reg   <= fe2_reg;
        end
    end

    // stage 4: interpolate, rounded; restore sign
    logic [SB+16:0] prod;
    logic [SB:0]    tval;

    assign prod = (SB+17)'(diff3_reg) * (SB+17)'(frac3_reg) + (SB+17)'(32'h8000);
    assign tval = sat3_reg ? TMAX : ((SB+1)'(lo3_reg) + prod[SB+16:16]);

    logic signed [SB:0]   wet4_reg;
    logic signed [SB-1:0] dry4_reg;
    logic                 fe4_reg;

    always_ff @(posedge clk)
    begin
        if (adv.s4)
        begin
            wet4_reg <= neg3_reg ? -$signed(tval) : $signed(tval);
            dry4_reg <= dry3_reg;
            fe4_reg  <= fe3_reg;
        end
    end

    assign wet     = wet4_reg;
    assign dry_out = dry4_reg;
    assign fe_out  = fe4_reg;

endmodule

// ----- design/tscd_mixer.sv -----
// ----------------------------------------------------------------------------
// tscd_mixer
// Dry/wet blend, then output gain with rounding and saturation.
// Two register stages.
// ----------------------------------------------------------------------------
module tscd_mixer
    import tscd_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                          clk,
    input  tscd_mix_adv_t                 adv,
    input  logic signed [SAMPLE_BITS:0]   wet,
    input  logic signed [SAMPLE_BITS-1:0] dry,
    input  logic                          fe_in,
    input  logic [CFG_W-1:0]              wet_mix,
    input  logic [CFG_W-1:0]              output_gain,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic                          frame_end_out
);

    localparam int SB = SAMPLE_BITS;
    localparam int F  = SB - 1;
    localparam int AW = SB + 19;
    localparam int XW = AW - 15;
    localparam int GW = XW + 17;
    localparam int RW = GW - 14;
    localparam logic signed [AW-1:0] HALF15 = AW'(16384);
    localparam logic signed [GW-1:0] HALF14 = GW'(8192);
    localparam logic signed [RW-1:0] RES_HI = {{(RW-F){1'b0}}, {F{1'b1}}};
    localparam logic signed [RW-1:0] RES_LO = {{(RW-F){1'b1}}, {F{1'b0}}};

    // stage 5: blend; mix above full scale counts as fully wet
    logic [CFG_W-1:0]       mix_eff;
    logic signed [CFG_W:0]  mix_s;
    logic signed [CFG_W:0]  dry_s;
    logic signed [AW-1:0]   wet_term;
    logic signed [AW-1:0]   dry_term;
    logic signed [AW-1:0]   acc;

    assign mix_eff  = (wet_mix > MIX_FULL) ? MIX_FULL : wet_mix;
    assign mix_s    = $signed({1'b0, mix_eff});
    assign dry_s    = $signed({1'b0, MIX_FULL}) - mix_s;
    assign wet_term = AW'(mix_s) * AW'(wet);
    assign dry_term = AW'(dry_s) * AW'(dry);
    assign acc      = wet_term + dry_term + HALF15;

    logic signed [XW-1:0] mixed5_reg;
    logic                 fe5_reg;

    always_ff @(posedge clk)
    begin
        if (adv.s5)
        begin
            mixed5_reg <= XW'(acc >>> 15);
            fe5_reg    <= fe_in;
        end
    end

    // stage 6: output gain, round, clamp
    logic signed [GW-1:0] gprod;
    logic signed [RW-1:0] res;
    logic signed [SB-1:0] res_sat;

    assign gprod = GW'(mixed5_reg) * GW'($signed({1'b0, output_gain})) + HALF14;
    assign res   = RW'(gprod >>> 14);

    always_comb
    begin
        if (res > RES_HI)
            res_sat = RES_HI[SB-1:0];
        else if (res < RES_LO)
            res_sat = RES_LO[SB-1:0];
        else
            res_sat = res[SB-1:0];
    end

    logic signed [SB-1:0] out6_reg;
    logic                 fe6_reg;

    always_ff @(posedge clk)
    begin
        if (adv.s6)
        begin
            out6_reg <= res_sat;
            fe6_reg  <= fe5_reg;
        end
    end

    assign sample_out    = out6_reg;
    assign frame_end_out = fe6_reg;

endmodule
